### design/bmf_pkg.sv
// Shared constants, types and the reciprocal table of the box mean filter.
// No dependencies.
`default_nettype none
package bmf_pkg;

    localparam int PIX_W          = 8;
    localparam int WS_W           = 4;
    localparam int FW_W           = 11;
    localparam int FH_W           = 11;
    localparam int POS_W          = 10;
    localparam int HEIGHT_LIMIT   = 1024;
    localparam int MAX_WINDOW_DEF = 8;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int QUEUE_DEPTH    = 4;
    localparam int RECIP_SHIFT    = 24;
    localparam int RECIP_W        = 25;
    localparam int RECIP_SPLIT    = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    // per-column control that rides with each column sum
    typedef struct packed {
        logic             emit;
        logic             done;
        logic             restart;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_col_ctl;

    localparam int CTL_W = $bits(t_col_ctl);

    // ceil(2^24 / (ws*ws)); exact truncated quotient for sums below 2^24/(ws*ws)
    function automatic logic [RECIP_W-1:0] recip(input logic [4:0] ws);
        logic [RECIP_W-1:0] v;
        unique case (ws)
            5'd1:    v = 25'd16777216;
            5'd2:    v = 25'd4194304;
            5'd3:    v = 25'd1864136;
            5'd4:    v = 25'd1048576;
            5'd5:    v = 25'd671089;
            5'd6:    v = 25'd466034;
            5'd7:    v = 25'd342393;
            5'd8:    v = 25'd262144;
            5'd9:    v = 25'd207127;
            5'd10:   v = 25'd167773;
            5'd11:   v = 25'd138655;
            5'd12:   v = 25'd116509;
            5'd13:   v = 25'd99274;
            5'd14:   v = 25'd85599;
            5'd15:   v = 25'd74566;
            5'd16:   v = 25'd65536;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/bmf_front.sv
// Front end: pixel positions, line memories and vertical column sums.
// Depends on bmf_pkg.
`default_nettype none
module bmf_front #(
    parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
    parameter int SW         = $clog2(MAX_WINDOW + 1),
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int CS_W       = $clog2(MAX_WINDOW * 255 + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_restart,
    input  wire [SW-1:0]                 i_ws,
    input  wire [CW:0]                   i_width,
    input  wire [bmf_pkg::FH_W-1:0]      i_height,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [bmf_pkg::PIX_W-1:0]     i_pixel,
    input  wire [$clog2(bmf_pkg::QUEUE_DEPTH+1)-1:0] i_q_count,
    output logic                         o_push,
    output logic [CS_W-1:0]              o_cs,
    output bmf_pkg::t_col_ctl            o_ctl
);

    logic [CW-1:0]                r_col;
    logic [bmf_pkg::POS_W-1:0]    r_row;
    logic [SW-1:0]                r_slot;
    logic                         r_f1v;
    logic [bmf_pkg::PIX_W-1:0]    r_f1pix;
    logic [SW-1:0]                r_f1slot;
    bmf_pkg::t_col_ctl            r_f1ctl;
    logic [bmf_pkg::PIX_W-1:0]    r_rd [MAX_WINDOW];
    logic                         acc;
    logic                         last_col;
    logic                         last_row;
    bmf_pkg::t_col_ctl            n_ctl;

    // in-flight read counts against queue space
    assign o_ready = (int'(i_q_count) + int'(r_f1v)) < bmf_pkg::QUEUE_DEPTH;
    assign acc     = i_valid && o_ready;

    assign last_col = (int'(r_col) + 1) == int'(i_width);
    assign last_row = (int'(r_row) + 1) == int'(i_height);

    always_comb begin
        n_ctl.emit    = ((int'(r_row) + 1) >= int'(i_ws)) && ((int'(r_col) + 1) >= int'(i_ws));
        n_ctl.done    = last_col && last_row;
        n_ctl.restart = (r_col == '0);
        n_ctl.col     = bmf_pkg::POS_W'(int'(r_col) + 1 - int'(i_ws));
        n_ctl.row     = bmf_pkg::POS_W'(int'(r_row) + 1 - int'(i_ws));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (acc) begin
            if (last_col) begin
                r_col <= '0;
                if (last_row) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_slot <= ((int'(r_slot) + 1) == int'(i_ws)) ? '0 : r_slot + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1v <= 1'b0;
        end else begin
            r_f1v <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_f1pix  <= i_pixel;
            r_f1slot <= r_slot;
            r_f1ctl  <= n_ctl;
        end
    end

    // one line memory per window row
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_line
        logic [bmf_pkg::PIX_W-1:0] mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (acc) begin
                if (int'(r_slot) == g) begin
                    mem[r_col] <= i_pixel;
                end
                r_rd[g] <= mem[r_col];
            end
        end
    end

    // the row being written is bypassed with the fresh pixel
    always_comb begin
        o_cs = '0;
        for (int s = 0; s < MAX_WINDOW; s++) begin
            if (s < int'(i_ws)) begin
                if (s == int'(r_f1slot)) begin
                    o_cs = o_cs + CS_W'(r_f1pix);
                end else begin
                    o_cs = o_cs + CS_W'(r_rd[s]);
                end
            end
        end
    end

    assign o_push = r_f1v;
    assign o_ctl  = r_f1ctl;

endmodule
`default_nettype wire

### design/bmf_queue.sv
// Short FIFO between front and back ends.
// Depends on bmf_pkg.
`default_nettype none
module bmf_queue #(
    parameter int DW = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire [DW-1:0]        i_data,
    input  wire                 i_pop,
    output logic                o_nonempty,
    output logic [DW-1:0]       o_data,
    output logic [$clog2(bmf_pkg::QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(bmf_pkg::QUEUE_DEPTH);

    logic [DW-1:0] r_mem [bmf_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [$clog2(bmf_pkg::QUEUE_DEPTH+1)-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data     = r_mem[r_rp];
    assign o_nonempty = (r_cnt != '0);
    assign o_count    = r_cnt;

endmodule
`default_nettype wire

### design/bmf_back.sv
// Back end: horizontal sum of column sums, reciprocal multiply, output register.
// Depends on bmf_pkg.
`default_nettype none
module bmf_back #(
    parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF,
    parameter int SW         = $clog2(MAX_WINDOW + 1),
    parameter int CS_W       = $clog2(MAX_WINDOW * 255 + 1),
    parameter int SUM_W      = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1)
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire [SW-1:0]              i_ws,
    input  wire                       i_q_nonempty,
    input  wire [CS_W-1:0]            i_cs,
    input  bmf_pkg::t_col_ctl         i_ctl,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [bmf_pkg::PIX_W-1:0] o_mean,
    output logic [bmf_pkg::POS_W-1:0] o_col,
    output logic [bmf_pkg::POS_W-1:0] o_row,
    output logic                      o_done
);

    localparam int LO_W = bmf_pkg::RECIP_SPLIT;
    localparam int HI_W = bmf_pkg::RECIP_W - LO_W;
    localparam int TOT_W = SUM_W + bmf_pkg::RECIP_W;

    logic [CS_W-1:0]         r_tap [MAX_WINDOW];
    logic [CS_W-1:0]         n_tap [MAX_WINDOW];
    logic [SUM_W-1:0]        n_sum;
    logic                    adv;
    logic                    r_av;
    logic [SUM_W-1:0]        r_asum;
    bmf_pkg::t_col_ctl       r_actl;
    logic                    r_bv;
    logic [SUM_W+HI_W-1:0]   r_phi;
    logic [SUM_W+LO_W-1:0]   r_plo;
    bmf_pkg::t_col_ctl       r_bctl;
    logic [bmf_pkg::RECIP_W-1:0] rc;
    logic [TOT_W-1:0]        total;
    logic                    r_ov;
    logic [bmf_pkg::PIX_W-1:0] r_mean;
    bmf_pkg::t_col_ctl       r_octl;

    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && i_q_nonempty;
    assign rc    = bmf_pkg::recip(5'(i_ws));

    // shift in the new column; a line start clears older columns
    always_comb begin
        n_tap[0] = i_cs;
        for (int i = 1; i < MAX_WINDOW; i++) begin
            n_tap[i] = i_ctl.restart ? '0 : r_tap[i-1];
        end
        n_sum = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (i < int'(i_ws)) n_sum = n_sum + SUM_W'(n_tap[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tap  <= n_tap;
            r_asum <= n_sum;
            r_actl <= i_ctl;
        end
        if (adv) begin
            r_phi  <= (SUM_W+HI_W)'(r_asum) * (SUM_W+HI_W)'(rc[bmf_pkg::RECIP_W-1:LO_W]);
            r_plo  <= (SUM_W+LO_W)'(r_asum) * (SUM_W+LO_W)'(rc[LO_W-1:0]);
            r_bctl <= r_actl;
            r_mean <= total[bmf_pkg::RECIP_SHIFT +: bmf_pkg::PIX_W];
            r_octl <= r_bctl;
        end
    end

    assign total = (TOT_W'(r_phi) << LO_W) + TOT_W'(r_plo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_av <= o_pop;
            r_bv <= r_av;
            r_ov <= r_bv && r_bctl.emit;
        end
    end

    assign o_valid = r_ov;
    assign o_mean  = r_mean;
    assign o_col   = r_octl.col;
    assign o_row   = r_octl.row;
    assign o_done  = r_octl.done;

endmodule
`default_nettype wire

### design/box_mean_filter_unit.sv
// Top level of the box mean filter: configuration registers and the three parts.
// Depends on bmf_pkg, bmf_front, bmf_queue, bmf_back.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[7:0] pixel
//  m_axis   | out       | tdata mean_pixel, out_col, out_row; tlast frame_done
//  cfg      | in        | index 0 window_size, 1 frame_width, 2 frame_height
//
// One pixel per cycle is accepted while the front does not stall; m_axis_tvalid
// rises after the front register, the queue and the back-end registers a, b and output.
// Front stalls when queue entries plus the read in flight reach 4;
// back stalls on m_axis_tready.
// Synchronous active-low reset; line memories are not cleared.
// A config write restarts the frame position.
`default_nettype none
module box_mean_filter_unit #(
    parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,    // [7:0] pixel
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] mean_pixel, [17:8] out_col, [27:18] out_row
    output logic       m_axis_tlast,    // frame_done
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [bmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [bmf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW    = $clog2(MAX_WINDOW + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CS_W  = $clog2(MAX_WINDOW * 255 + 1);
    localparam int QC_W  = $clog2(bmf_pkg::QUEUE_DEPTH + 1);
    localparam int QD_W  = CS_W + bmf_pkg::CTL_W;

    logic [bmf_pkg::WS_W-1:0] r_ws;
    logic [bmf_pkg::FW_W-1:0] r_fw;
    logic [bmf_pkg::FH_W-1:0] r_fh;
    logic                     cfg_wr;
    logic [SW-1:0]            ws_c;
    logic [CW:0]              w_c;
    logic [bmf_pkg::FH_W-1:0] h_c;
    logic                     push;
    logic [CS_W-1:0]          f_cs;
    bmf_pkg::t_col_ctl        f_ctl;
    logic                     pop;
    logic                     q_ne;
    logic [QD_W-1:0]          q_out;
    logic [QC_W-1:0]          q_cnt;
    bmf_pkg::t_col_ctl        b_ctl;
    logic [bmf_pkg::PIX_W-1:0] mean;
    logic [bmf_pkg::POS_W-1:0] ocol;
    logic [bmf_pkg::POS_W-1:0] orow;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && (i_cfg_index == bmf_pkg::CFG_WINDOW ||
                                    i_cfg_index == bmf_pkg::CFG_WIDTH ||
                                    i_cfg_index == bmf_pkg::CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= bmf_pkg::WS_W'(3);
            r_fw <= bmf_pkg::FW_W'(640);
            r_fh <= bmf_pkg::FH_W'(480);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bmf_pkg::CFG_WINDOW: r_ws <= i_cfg_data[bmf_pkg::WS_W-1:0];
                bmf_pkg::CFG_WIDTH:  r_fw <= i_cfg_data[bmf_pkg::FW_W-1:0];
                bmf_pkg::CFG_HEIGHT: r_fh <= i_cfg_data[bmf_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range settings saturate
    always_comb begin
        if (r_ws == '0)                    ws_c = SW'(1);
        else if (int'(r_ws) > MAX_WINDOW)  ws_c = SW'(MAX_WINDOW);
        else                               ws_c = SW'(r_ws);
        if (r_fw == '0)                    w_c = (CW+1)'(1);
        else if (int'(r_fw) > MAX_WIDTH)   w_c = (CW+1)'(MAX_WIDTH);
        else                               w_c = (CW+1)'(r_fw);
        if (r_fh == '0)                    h_c = bmf_pkg::FH_W'(1);
        else if (int'(r_fh) > bmf_pkg::HEIGHT_LIMIT)
                                           h_c = bmf_pkg::FH_W'(bmf_pkg::HEIGHT_LIMIT);
        else                               h_c = r_fh;
    end

    bmf_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_ws      (ws_c),
        .i_width   (w_c),
        .i_height  (h_c),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_pixel   (s_axis_tdata),
        .i_q_count (q_cnt),
        .o_push    (push),
        .o_cs      (f_cs),
        .o_ctl     (f_ctl)
    );

    bmf_queue #(
        .DW (QD_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     ({f_cs, f_ctl}),
        .i_pop      (pop),
        .o_nonempty (q_ne),
        .o_data     (q_out),
        .o_count    (q_cnt)
    );

    assign b_ctl = q_out[bmf_pkg::CTL_W-1:0];

    bmf_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ws         (ws_c),
        .i_q_nonempty (q_ne),
        .i_cs         (q_out[QD_W-1:bmf_pkg::CTL_W]),
        .i_ctl        (b_ctl),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_mean       (mean),
        .o_col        (ocol),
        .o_row        (orow),
        .o_done       (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, orow, ocol, mean};

endmodule
`default_nettype wire
